@@ src/xalu_pkg.sv @@
// Shared types and constants for the x86-style integer ALU.
package xalu_pkg;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,
      OP_ADC  = 5'd1,
      OP_SUB  = 5'd2,
      OP_SBB  = 5'd3,
      OP_MUL  = 5'd4,
      OP_IMUL = 5'd5,
      OP_DIV  = 5'd6,
      OP_IDIV = 5'd7,
      OP_MOD  = 5'd8,
      OP_IMOD = 5'd9,
      OP_AND  = 5'd10,
      OP_XOR  = 5'd11,
      OP_OR   = 5'd12,
      OP_SHL  = 5'd13,
      OP_SHR  = 5'd14,
      OP_SAR  = 5'd15,
      OP_NEG  = 5'd16
   } op_type;

   localparam logic [1:0] SIZE_8    = 2'd0;
   localparam logic [1:0] SIZE_16   = 2'd1;
   localparam logic [1:0] SIZE_32   = 2'd2;
   // Spare size code, handled as 32 bits.
   localparam logic [1:0] SIZE_WIDE = 2'd3;

   localparam int FLAG_CF = 0;
   localparam int FLAG_PF = 1;
   localparam int FLAG_ZF = 2;
   localparam int FLAG_SF = 3;
   localparam int FLAG_OF = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIX,
      ST_OUT
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic div_fix;
      logic commit;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic is_div;
      logic div_last;
   } status_type;

   // Operation beat.
   typedef struct packed {
      logic [4:0]  op;
      logic [1:0]  size_code;
      logic [31:0] src;
      logic [63:0] dest;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [63:0] result;
      logic        carry;
      logic        parity;
      logic        zero;
      logic        sign_bit;
      logic        overflow;
      logic        divide_error;
   } rsp_type;

   localparam int DIV_STEPS = 64;
   localparam int DIV_CNT_W = 7;

   // Even parity of the low byte.
   function automatic logic even_parity(input logic [7:0] v);
      even_parity = ~(^v);
   endfunction

endpackage

@@ src/xalu_if.sv @@
// Valid/ready channel interface carrying a generic payload.
interface xalu_if #(
   parameter type payload_type = logic
) (
   input logic clock
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ src/x86_integer_alu_with_flags.sv @@
// Top level of the x86-style integer ALU with status flags.
//
// Usage: an operation beat arrives on the req channel (op, size_code, src,
// dest); exactly one result beat leaves on the rsp channel with the masked
// result, CF, PF, ZF, SF, OF and divide_error.
// Timing: rsp_valid rises in the cycle after acceptance for every operation
// except div, idiv, mod and imod, which first pass through the load, 64 iterations
// of the radix-2 restoring divider and the sign correction.
// Throughput: one beat a cycle for non-divide operations while the receiver
// keeps taking results; a divide holds off new requests until its result is taken.
// The held result register parts the two sides: a new request is taken in
// the same cycle the pending result is taken.
// Reset (synchronous, active high) clears the stored flags to zero and
// empties the block. When the receiver stalls, the result is held stable and
// no new request is taken.
module x86_integer_alu_with_flags (
   input logic clock,
   input logic reset,
   xalu_if.sink   req,
   xalu_if.source rsp
);
   xalu_pkg::cmd_type    cmd;
   xalu_pkg::status_type status;

   xalu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   xalu_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req.payload.op),
      .req_size_code    (req.payload.size_code),
      .req_src          (req.payload.src),
      .req_dest         (req.payload.dest),
      .rsp_result       (rsp.payload.result),
      .rsp_flags        ({rsp.payload.overflow, rsp.payload.sign_bit, rsp.payload.zero,
                          rsp.payload.parity, rsp.payload.carry}),
      .rsp_divide_error (rsp.payload.divide_error)
   );
endmodule

@@ src/xalu_ctrl.sv @@
// Controller state machine for the ALU: sequences load, divide and result beat.
module xalu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  xalu_pkg::status_type    status,
   output xalu_pkg::cmd_type       cmd
);
   xalu_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xalu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      unique case (state_ff)
         xalu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.is_div ? xalu_pkg::ST_DIV : xalu_pkg::ST_OUT;
               cmd.div_start = status.is_div;
               cmd.commit = ~status.is_div;
            end
         end
         xalu_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = xalu_pkg::ST_FIX;
         end
         xalu_pkg::ST_FIX: begin
            cmd.div_fix = 1'b1;
            state_in = xalu_pkg::ST_OUT;
         end
         xalu_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
            if (rsp_ready) begin
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = status.is_div ? xalu_pkg::ST_DIV : xalu_pkg::ST_OUT;
                  cmd.div_start = status.is_div;
                  cmd.commit = ~status.is_div;
               end else begin
                  state_in = xalu_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = xalu_pkg::ST_IDLE;
      endcase
   end
endmodule

@@ src/xalu_dp.sv @@
// Datapath for the ALU: single-cycle ops, multiply, radix-2 divider and flags.
module xalu_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  xalu_pkg::cmd_type    cmd,
   output xalu_pkg::status_type status,
   input  logic [4:0]           req_op,
   input  logic [1:0]           req_size_code,
   input  logic [31:0]          req_src,
   input  logic [63:0]          req_dest,
   output logic [63:0]          rsp_result,
   output logic [4:0]           rsp_flags,
   output logic                 rsp_divide_error
);
   // Size decode
   logic [31:0] m;
   logic [63:0] m2;
   logic [5:0]  size;
   always_comb begin
      unique case (req_size_code)
         xalu_pkg::SIZE_8:  begin m = 32'hFF;   m2 = 64'hFFFF;      size = 6'd8;  end
         xalu_pkg::SIZE_16: begin m = 32'hFFFF; m2 = 64'hFFFF_FFFF; size = 6'd16; end
         default:           begin m = 32'hFFFF_FFFF; m2 = '1;       size = 6'd32; end
      endcase
   end

   logic [4:0]  flags_ff, flags_in;
   logic [31:0] a, b;
   logic        cin;
   assign a   = req_dest[31:0] & m;
   assign b   = req_src & m;
   assign cin = flags_ff[xalu_pkg::FLAG_CF];

   logic is_div, is_sdiv;
   assign is_div  = (req_op == xalu_pkg::OP_DIV) || (req_op == xalu_pkg::OP_IDIV) ||
                    (req_op == xalu_pkg::OP_MOD) || (req_op == xalu_pkg::OP_IMOD);
   assign is_sdiv = (req_op == xalu_pkg::OP_IDIV) || (req_op == xalu_pkg::OP_IMOD);

   // Top bit of a masked value
   function automatic logic topbit(input logic [31:0] v, input logic [5:0] sz);
      topbit = v[5'(sz - 6'd1)];
   endfunction

   function automatic logic [31:0] sx32(input logic [31:0] v, input logic [5:0] sz);
      logic [31:0] s;
      s = 32'd1 << 5'(sz - 6'd1);
      sx32 = (v ^ s) - s;
   endfunction

   // Single-cycle result and flags
   logic [63:0] res;
   logic [4:0]  nf;
   logic [32:0] full;
   logic [32:0] bc;
   logic [63:0] prod;
   logic [4:0]  cnt;
   logic [63:0] shv;
   logic        cf;
   logic        setres;
   logic [31:0] sa;
   logic [31:0] sb;
   always_comb begin
      res    = '0;
      nf     = flags_ff;
      setres = 1'b0;
      full   = '0;
      bc     = '0;
      prod   = '0;
      shv    = '0;
      cf     = 1'b0;
      sa     = sx32(a, size);
      sb     = sx32(b, size);
      cnt    = req_src[4:0];
      unique case (req_op)
         xalu_pkg::OP_ADD, xalu_pkg::OP_ADC: begin
            full = {1'b0, a} + {1'b0, b} +
                   33'((req_op == xalu_pkg::OP_ADC) ? cin : 1'b0);
            res = {32'd0, full[31:0] & m};
            nf[xalu_pkg::FLAG_CF] = full[6'(size)];
            nf[xalu_pkg::FLAG_OF] = topbit(~(a ^ b) & (a ^ res[31:0]), size);
            setres = 1'b1;
         end
         xalu_pkg::OP_SUB, xalu_pkg::OP_SBB: begin
            bc = {1'b0, b} + 33'((req_op == xalu_pkg::OP_SBB) ? cin : 1'b0);
            res = {32'd0, (a - bc[31:0]) & m};
            nf[xalu_pkg::FLAG_CF] = {1'b0, a} < bc;
            nf[xalu_pkg::FLAG_OF] = topbit((a ^ b) & (a ^ res[31:0]), size);
            setres = 1'b1;
         end
         xalu_pkg::OP_MUL: begin
            prod = {32'd0, a} * {32'd0, b};
            res = prod & m2;
            nf[xalu_pkg::FLAG_CF] = (res >> size) != 64'd0;
            nf[xalu_pkg::FLAG_OF] = (res >> size) != 64'd0;
         end
         xalu_pkg::OP_IMUL: begin
            prod = {{32{sa[31]}}, sa} * {{32{sb[31]}}, sb};
            res = prod & m2;
         end
         xalu_pkg::OP_AND, xalu_pkg::OP_XOR, xalu_pkg::OP_OR: begin
            res = {32'd0, (req_op == xalu_pkg::OP_AND) ? (a & b) :
                          (req_op == xalu_pkg::OP_XOR) ? (a ^ b) : (a | b)};
            nf[xalu_pkg::FLAG_CF] = 1'b0;
            nf[xalu_pkg::FLAG_OF] = 1'b0;
            setres = 1'b1;
         end
         xalu_pkg::OP_SHL, xalu_pkg::OP_SHR, xalu_pkg::OP_SAR: begin
            if (cnt == 5'd0) begin
               res = {32'd0, a};
            end else begin
               if (req_op == xalu_pkg::OP_SHL) begin
                  shv = {32'd0, a} << cnt;
                  cf  = shv[6'(size)];
                  res = shv & {32'd0, m};
                  if (cnt == 5'd1)
                     nf[xalu_pkg::FLAG_OF] = topbit(res[31:0], size) ^ cf;
               end else if (req_op == xalu_pkg::OP_SHR) begin
                  shv = {32'd0, a};
                  cf  = a[cnt - 5'd1];
                  res = shv >> cnt;
                  if (cnt == 5'd1) nf[xalu_pkg::FLAG_OF] = topbit(a, size);
               end else begin
                  shv = {{32{sa[31]}}, sa};
                  cf  = sa[cnt - 5'd1];
                  res = (64'($signed(shv) >>> cnt)) & {32'd0, m};
                  if (cnt == 5'd1) nf[xalu_pkg::FLAG_OF] = 1'b0;
               end
               nf[xalu_pkg::FLAG_CF] = cf;
               setres = 1'b1;
            end
         end
         xalu_pkg::OP_NEG: begin
            res = {32'd0, (32'd0 - a) & m};
            nf[xalu_pkg::FLAG_CF] = a != 32'd0;
            nf[xalu_pkg::FLAG_OF] = a == (32'd1 << 5'(size - 6'd1));
            setres = 1'b1;
         end
         default: res = '0;
      endcase
      if (setres) begin
         nf[xalu_pkg::FLAG_PF] = xalu_pkg::even_parity(res[7:0]);
         nf[xalu_pkg::FLAG_ZF] = res == 64'd0;
         nf[xalu_pkg::FLAG_SF] = topbit(res[31:0], size);
      end
   end

   // Divider operand preparation (magnitudes for the signed forms)
   logic [63:0] n_ext, n_mag;
   logic [31:0] d_mag;
   logic        n_neg, d_neg;
   always_comb begin
      n_ext = req_dest & m2;
      n_neg = 1'b0;
      d_neg = 1'b0;
      if (is_sdiv) begin
         n_neg = n_ext[6'({size, 1'b0} - 7'd1)];
         d_neg = b[5'(size - 6'd1)];
      end
      n_mag = n_neg ? (64'd0 - (n_ext | ~m2)) : n_ext;
      d_mag = d_neg ? (32'd0 - (b | ~m)) : b;
   end

   // Restoring divider: one quotient bit a cycle
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dv_ff;
   logic        qneg_ff, rneg_ff, isrem_ff;
   logic [xalu_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [33:0] trial;
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[63]} - {2'b0, dv_ff};
      if (cmd.div_start) begin
         quo_in = n_mag;
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[62:0], ~trial[33]};
         rem_in = trial[33] ? {rem_ff[31:0], quo_ff[63]} : trial[32:0];
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // Status back to the controller
   assign status = {is_div,
                    cnt_ff == xalu_pkg::DIV_CNT_W'(xalu_pkg::DIV_STEPS - 1)};

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (cmd.div_start) begin
         dv_ff    <= d_mag;
         qneg_ff  <= n_neg ^ d_neg;
         rneg_ff  <= n_neg;
         isrem_ff <= (req_op == xalu_pkg::OP_MOD) || (req_op == xalu_pkg::OP_IMOD);
      end
   end

   // Result register and flag state
   logic [63:0] result_ff;
   logic        derr_ff;
   logic [31:0] mask_ff;
   logic [31:0] dsel;
   assign dsel = isrem_ff ? (rneg_ff ? 32'd0 - rem_ff[31:0] : rem_ff[31:0])
                          : (qneg_ff ? 32'd0 - quo_ff[31:0] : quo_ff[31:0]);

   always_comb begin
      flags_in = flags_ff;
      if (cmd.commit) flags_in = nf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      if (cmd.load) begin
         result_ff <= res;
         derr_ff   <= is_div && (b == 32'd0);
         mask_ff   <= m;
      end else if (cmd.div_fix) begin
         result_ff <= derr_ff ? 64'd0 : {32'd0, dsel & mask_ff};
      end
   end

   assign rsp_result       = result_ff;
   assign rsp_flags        = flags_ff;
   assign rsp_divide_error = derr_ff;
endmodule

@@ src/xalu_checker.sv @@
// Port-level checker for the ALU, bound to the top level.
module xalu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_result,
   input logic        rsp_divide_error
);
   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
      else $error("result changed while stalled");

   // No request taken while a result waits unclaimed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken under stall");

   // A divide error always reports a zero result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |-> rsp_result == 64'd0)
      else $error("divide error with nonzero result");

   // Empty after reset.
   assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind x86_integer_alu_with_flags xalu_checker u_xalu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_result       (rsp.payload.result),
   .rsp_divide_error (rsp.payload.divide_error)
);

@@ verif/x86_integer_alu_with_flags_tb.sv @@
// Self-checking testbench for the x86-style integer ALU: directed and random operations against a flag-tracking predictor.
module x86_integer_alu_with_flags_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam int unsigned N_RANDOM    = 1700;

   // Unused operation codes at both ends of the spare range.
   localparam logic [4:0] OP_SPARE_LO = 5'd17;
   localparam logic [4:0] OP_SPARE_HI = 5'd31;

   // Tracks the stored flags, predicts each result and checks it in order.
   class alu_scoreboard;
      xalu_pkg::rsp_type pending[$];
      logic [4:0]  flags;
      int unsigned n_errors;
      int unsigned n_checked;
      int unsigned n_div_err;

      function new();
         flags     = '0;
         n_errors  = 0;
         n_checked = 0;
         n_div_err = 0;
      endfunction

      function logic [63:0] sext(logic [63:0] v, int unsigned bits);
         logic [63:0] s;
         s = 64'd1 << (bits - 1);
         if (bits < 64) v &= (64'd1 << bits) - 1;
         return (v ^ s) - s;
      endfunction

      // Work out the result beat for one accepted operation.
      function void note_op(xalu_pkg::req_type r);
         int unsigned size, cnt;
         logic [63:0] m, m2, a, b, res, full, c, n, d, un, ud, v, s;
         logic [4:0]  f;
         logic        derr, cf, nneg, dneg, set_rf;
         xalu_pkg::rsp_type e;
         size   = (r.size_code == xalu_pkg::SIZE_8) ? 8 :
                  (r.size_code == xalu_pkg::SIZE_16) ? 16 : 32;
         m      = (64'd1 << size) - 1;
         m2     = (size == 32) ? '1 : (64'd1 << (2 * size)) - 1;
         a      = r.dest & m;
         b      = {32'd0, r.src} & m;
         f      = flags;
         res    = '0;
         derr   = 1'b0;
         set_rf = 1'b0;
         case (r.op)
            xalu_pkg::OP_ADD, xalu_pkg::OP_ADC: begin
               full = a + b + ((r.op == xalu_pkg::OP_ADC) ?
                               {63'd0, f[xalu_pkg::FLAG_CF]} : 64'd0);
               res  = full & m;
               f[xalu_pkg::FLAG_CF] = full[size];
               f[xalu_pkg::FLAG_OF] = 1'(((~(a ^ b)) & (a ^ res)) >> (size - 1));
               set_rf = 1'b1;
            end
            xalu_pkg::OP_SUB, xalu_pkg::OP_SBB: begin
               c   = (r.op == xalu_pkg::OP_SBB) ? {63'd0, f[xalu_pkg::FLAG_CF]} : 64'd0;
               res = (a - b - c) & m;
               f[xalu_pkg::FLAG_CF] = a < b + c;
               f[xalu_pkg::FLAG_OF] = 1'(((a ^ b) & (a ^ res)) >> (size - 1));
               set_rf = 1'b1;
            end
            xalu_pkg::OP_MUL: begin
               res = (a * b) & m2;
               f[xalu_pkg::FLAG_CF] = (res >> size) != 0;
               f[xalu_pkg::FLAG_OF] = f[xalu_pkg::FLAG_CF];
            end
            xalu_pkg::OP_IMUL: res = (sext(a, size) * sext(b, size)) & m2;
            xalu_pkg::OP_DIV, xalu_pkg::OP_MOD: begin
               n = r.dest & m2;
               if (b == 0) derr = 1'b1;
               else res = ((r.op == xalu_pkg::OP_DIV) ? n / b : n % b) & m;
            end
            xalu_pkg::OP_IDIV, xalu_pkg::OP_IMOD: begin
               n    = sext(r.dest, 2 * size);
               d    = sext(b, size);
               nneg = n[63];
               dneg = d[63];
               un   = nneg ? -n : n;
               ud   = dneg ? -d : d;
               if (b == 0) derr = 1'b1;
               else if (r.op == xalu_pkg::OP_IDIV) begin
                  v   = un / ud;
                  res = ((nneg != dneg) ? -v : v) & m;
               end else begin
                  v   = un % ud;
                  res = (nneg ? -v : v) & m;
               end
            end
            xalu_pkg::OP_AND, xalu_pkg::OP_XOR, xalu_pkg::OP_OR: begin
               res = (r.op == xalu_pkg::OP_AND) ? (a & b) :
                     (r.op == xalu_pkg::OP_XOR) ? (a ^ b) : (a | b);
               f[xalu_pkg::FLAG_CF] = 1'b0;
               f[xalu_pkg::FLAG_OF] = 1'b0;
               set_rf = 1'b1;
            end
            xalu_pkg::OP_SHL, xalu_pkg::OP_SHR, xalu_pkg::OP_SAR: begin
               cnt = r.src[4:0];
               if (cnt == 0) res = a;
               else begin
                  if (r.op == xalu_pkg::OP_SHL) begin
                     v   = a << cnt;
                     cf  = v[size];
                     res = v & m;
                     if (cnt == 1) f[xalu_pkg::FLAG_OF] = res[size-1] ^ cf;
                  end else if (r.op == xalu_pkg::OP_SHR) begin
                     cf  = a[cnt-1];
                     res = a >> cnt;
                     if (cnt == 1) f[xalu_pkg::FLAG_OF] = a[size-1];
                  end else begin
                     s   = sext(a, size);
                     cf  = s[cnt-1];
                     res = ($signed(s) >>> cnt) & m;
                     if (cnt == 1) f[xalu_pkg::FLAG_OF] = 1'b0;
                  end
                  f[xalu_pkg::FLAG_CF] = cf;
                  set_rf = 1'b1;
               end
            end
            xalu_pkg::OP_NEG: begin
               res = (-a) & m;
               f[xalu_pkg::FLAG_CF] = a != 0;
               f[xalu_pkg::FLAG_OF] = a == (64'd1 << (size - 1));
               set_rf = 1'b1;
            end
            default: res = '0;
         endcase
         if (set_rf) begin
            f[xalu_pkg::FLAG_PF] = ~^res[7:0];
            f[xalu_pkg::FLAG_ZF] = res == 0;
            f[xalu_pkg::FLAG_SF] = res[size-1];
         end
         flags          = f;
         e.result       = res;
         e.carry        = f[xalu_pkg::FLAG_CF];
         e.parity       = f[xalu_pkg::FLAG_PF];
         e.zero         = f[xalu_pkg::FLAG_ZF];
         e.sign_bit     = f[xalu_pkg::FLAG_SF];
         e.overflow     = f[xalu_pkg::FLAG_OF];
         e.divide_error = derr;
         if (derr) n_div_err++;
         pending.push_back(e);
      endfunction

      // Compare one result beat with the oldest prediction.
      function void check_result(xalu_pkg::rsp_type got);
         xalu_pkg::rsp_type e;
         if (pending.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected result beat %p", got);
            return;
         end
         e = pending.pop_front();
         n_checked++;
         if (got !== e) begin
            n_errors++;
            if (n_errors <= 10)
               $display("mismatch on result %0d: expected %p, got %p", n_checked, e, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int unsigned n_cycles = 0;
   bit  idle_on = 1'b1;
   alu_scoreboard sb = new();

   xalu_if #(.payload_type(xalu_pkg::req_type)) req_ch (.clock(clock));
   xalu_if #(.payload_type(xalu_pkg::rsp_type)) rsp_ch (.clock(clock));

   x86_integer_alu_with_flags dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always #5 clock = ~clock;

   // Monitor both channels; inputs noted before results are checked.
   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_op(req_ch.payload);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
      end
      if (n_cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", n_cycles);
         $display("FAIL");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result side back-pressure.
   initial begin
      int unsigned g;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = 1'b1;
         g = pick_gap();
         if (g > 0) begin
            @(negedge clock);
            rsp_ch.ready = 1'b0;
            repeat (g - 1) @(negedge clock);
         end
      end
   end

   // One operation beat, with a random gap ahead of it.
   task automatic send_op(input logic [4:0] op, input logic [1:0] sz,
                          input logic [31:0] src, input logic [63:0] dest);
      int unsigned g;
      g = pick_gap();
      if (g > 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid             = 1'b1;
      req_ch.payload.op        = op;
      req_ch.payload.size_code = sz;
      req_ch.payload.src       = src;
      req_ch.payload.dest      = dest;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic [63:0] rand_val();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return {32'd0, 32'h1 << $urandom_range(0, 31)};
         3: return {56'd0, 8'($urandom)};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      logic [4:0] op;
      int unsigned r;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: carries, borrows, products, divide corners, logic ops, shifts, neg, unused codes.
      idle_on = 1'b0;
      send_op(xalu_pkg::OP_ADD,  xalu_pkg::SIZE_8,  32'hFF,       64'h1);
      send_op(xalu_pkg::OP_ADC,  xalu_pkg::SIZE_8,  32'h7F,       64'h0);
      send_op(xalu_pkg::OP_SUB,  xalu_pkg::SIZE_16, 32'h1,        64'h0);
      send_op(xalu_pkg::OP_SBB,  xalu_pkg::SIZE_32, 32'h8000_0000, 64'h0);
      send_op(xalu_pkg::OP_MUL,  xalu_pkg::SIZE_32, 32'hFFFF_FFFF, 64'hFFFF_FFFF);
      send_op(xalu_pkg::OP_IMUL, xalu_pkg::SIZE_8,  32'h80,       64'h80);
      send_op(xalu_pkg::OP_DIV,  xalu_pkg::SIZE_16, 32'h0,        64'h1234);
      send_op(xalu_pkg::OP_DIV,  xalu_pkg::SIZE_8,  32'h1,        64'hFFFF);
      send_op(xalu_pkg::OP_IDIV, xalu_pkg::SIZE_32, 32'hFFFF_FFFD,
              64'h8000_0000_0000_0000);
      send_op(xalu_pkg::OP_MOD,  xalu_pkg::SIZE_32, 32'h7,
              64'hFFFF_FFFF_FFFF_FFFF);
      send_op(xalu_pkg::OP_IMOD, xalu_pkg::SIZE_16, 32'h7,        64'hFFFF_FFF9);
      send_op(xalu_pkg::OP_IMOD, xalu_pkg::SIZE_8,  32'h0,        64'h5);
      send_op(xalu_pkg::OP_AND,  xalu_pkg::SIZE_WIDE, 32'hF0F0_F0F0,
              64'hFFFF_FFFF_FFFF_FFFF);
      send_op(xalu_pkg::OP_XOR,  xalu_pkg::SIZE_8,  32'hAA,       64'hAA);
      send_op(xalu_pkg::OP_OR,   xalu_pkg::SIZE_16, 32'h8000,     64'h1);
      send_op(xalu_pkg::OP_SHL,  xalu_pkg::SIZE_8,  32'h1,        64'hC0);
      send_op(xalu_pkg::OP_SHL,  xalu_pkg::SIZE_8,  32'h0,        64'h3);
      send_op(xalu_pkg::OP_SHL,  xalu_pkg::SIZE_8,  32'hFFFF_FFFF, 64'hFF);
      send_op(xalu_pkg::OP_SHR,  xalu_pkg::SIZE_16, 32'h1,        64'h8001);
      send_op(xalu_pkg::OP_SAR,  xalu_pkg::SIZE_8,  32'h1,        64'h81);
      send_op(xalu_pkg::OP_SAR,  xalu_pkg::SIZE_8,  32'h14,       64'h80);
      send_op(xalu_pkg::OP_NEG,  xalu_pkg::SIZE_8,  32'h0,        64'h80);
      send_op(xalu_pkg::OP_NEG,  xalu_pkg::SIZE_32, 32'h0,        64'h0);
      send_op(OP_SPARE_LO,       xalu_pkg::SIZE_8,  32'h5,        64'h5);
      send_op(OP_SPARE_HI,       xalu_pkg::SIZE_WIDE, 32'hFFFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFF);

      // Random: mostly real operations, some unused codes, stretches without idling.
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 200 == 0) idle_on = $urandom_range(0, 2) != 0;
         r  = $urandom_range(0, 99);
         op = (r < 94) ? 5'($urandom_range(0, 16)) : 5'($urandom_range(17, 31));
         send_op(op, 2'($urandom_range(0, 3)),
                 ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 40))
                                             : 32'(rand_val()),
                 ($urandom_range(0, 3) == 0) ? rand_val() : {$urandom, $urandom});
      end
      @(negedge clock);
      req_ch.valid = 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("%0d results checked, %0d with divide error, %0d mismatches",
               sb.n_checked, sb.n_div_err, sb.n_errors);
      if (sb.n_errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
